// ===== sv/jets_pkg.sv =====
// jets_pkg: shared types, constants and helpers for the julia escape-time pixel block
// no dependencies; used by every module under sv/
package jets_pkg;

    localparam int COORD_W    = 12;
    localparam int CNT_W      = 16;
    localparam int Z_W        = 32;
    localparam int STEP_W     = 31;
    localparam int SIZE_W     = 13;
    localparam int PROD_W     = 64;
    localparam int WIDE_W     = 65;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 40;

    localparam logic [STEP_W-1:0] RST_PIXEL_STEP  = 31'd786432;
    localparam logic [Z_W-1:0]    RST_CONST_REAL  = 32'd76504269;
    localparam logic [Z_W-1:0]    RST_CONST_IMAG  = 32'd2684355;
    localparam logic [CNT_W-1:0]  RST_ITER_LIMIT  = 16'd256;
    localparam logic [SIZE_W-1:0] RST_FRAME_W     = 13'd1024;
    localparam logic [SIZE_W-1:0] RST_FRAME_H     = 13'd768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_STEP   = 3'd0,
        CFG_CENTER_REAL  = 3'd1,
        CFG_CENTER_IMAG  = 3'd2,
        CFG_CONST_REAL   = 3'd3,
        CFG_CONST_IMAG   = 3'd4,
        CFG_ITER_LIMIT   = 3'd5,
        CFG_FRAME_WIDTH  = 3'd6,
        CFG_FRAME_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [STEP_W-1:0]     pixel_step;
        logic signed [Z_W-1:0] center_real;
        logic signed [Z_W-1:0] center_imag;
        logic signed [Z_W-1:0] const_real;
        logic signed [Z_W-1:0] const_imag;
        logic [CNT_W-1:0]      iter_limit;
        logic [SIZE_W-1:0]     frame_width;
        logic [SIZE_W-1:0]     frame_height;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_MUL,
        ST_START,
        ST_ITER_MUL,
        ST_ITER_TEST,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture pixel coordinate, clear count
        logic mul_start;  // multiply offsets by pixel step
        logic set_start;  // form start point from products
        logic mul_iter;   // form re*re, im*im, re*im
        logic step;       // take one iteration, bump count
        logic emit;       // move result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic limit_hit;  // count has reached iteration limit
        logic below;      // |z|^2 of the registered products is below 4
        logic out_full;   // output register holds an untaken result
    } t_stat;

    // clamp a wide signed value to the 32-bit z range
    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
        logic fits;
        fits = (v[WIDE_W-1:Z_W-1] == {(WIDE_W-Z_W+1){v[Z_W-1]}});
        if (fits) begin
            sat_z = v[Z_W-1:0];
        end else if (v[WIDE_W-1]) begin
            sat_z = {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            sat_z = {1'b0, {(Z_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== sv/julia_escape_time_pixel.sv =====
// julia_escape_time_pixel: top level, julia-set escape-time count for one pixel per transfer
// depends on jets_pkg, jets_cfg, jets_ctrl, jets_dp
//
// channel   dir  signals                          moves
// s_*       in   s_tvalid s_tready s_tdata[23:0]  pixel coordinate
// m_*       out  m_tvalid m_tready m_tdata[39:0]  iteration count and echoed coordinate
// i_cfg_*   in   i_cfg_we i_cfg_idx i_cfg_wdata   register write, no wait
//
// after its transfer a pixel keeps s_tready low until its result is emitted, whether it
// escapes or the limit ends it: each iteration is a pass through the three shared 32x32
// multipliers, followed by the escape test and z update
// reset is synchronous, active low; it loads the register defaults, no clearing pass
// a result waiting in the output register does not stop the next pixel; only a
// second finished pixel stalls in the done state until m_tready takes the first
module julia_escape_time_pixel #(
    parameter int FRAC_BITS = 28
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel_x [11:0], pixel_y [23:12]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [jets_pkg::S_DATA_W-1:0]   s_tdata,
    // iter_count [15:0], out_x [27:16], out_y [39:28]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [jets_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            i_cfg_we,
    input  logic [jets_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jets_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CW = jets_pkg::COORD_W;

    jets_pkg::t_cfg  w_cfg;
    jets_pkg::t_cmd  w_cmd;
    jets_pkg::t_stat w_stat;
    logic [jets_pkg::CNT_W-1:0] w_count;
    logic [CW-1:0]              w_x;
    logic [CW-1:0]              w_y;

    jets_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    // sequencer: idle, start products, start point, product/test pairs, then done
    jets_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    jets_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .i_px       (s_tdata[CW-1:0]),
        .i_py       (s_tdata[2*CW-1:CW]),
        .o_stat     (w_stat),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_count    (w_count),
        .o_x        (w_x),
        .o_y        (w_y)
    );

    // fields packed from the lowest bit up, 40 bits is already whole bytes
    assign m_tdata = {w_y, w_x, w_count};

`ifndef ASSERT_OFF
    // a pixel transfer starts the sequencer, so the next cycle takes no pixel
    a_one_pixel_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second pixel taken while one is in flight");

    // a result never counts more iterations than the limit allows
    a_count_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[jets_pkg::CNT_W-1:0] <= w_cfg.iter_limit))
        else $error("iteration count above limit");

    // the output register is loaded only when it is free or being emptied
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwritten before transfer");
`endif

endmodule

// ===== sv/jets_cfg.sv =====
// jets_cfg: configuration register file, one write port, no read-back
// depends on jets_pkg
module jets_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [jets_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [jets_pkg::CFG_DATA_W-1:0] i_wdata,
    output jets_pkg::t_cfg                  o_cfg
);

    jets_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_step   <= jets_pkg::RST_PIXEL_STEP;
            r_cfg.center_real  <= '0;
            r_cfg.center_imag  <= '0;
            r_cfg.const_real   <= jets_pkg::RST_CONST_REAL;
            r_cfg.const_imag   <= jets_pkg::RST_CONST_IMAG;
            r_cfg.iter_limit   <= jets_pkg::RST_ITER_LIMIT;
            r_cfg.frame_width  <= jets_pkg::RST_FRAME_W;
            r_cfg.frame_height <= jets_pkg::RST_FRAME_H;
        end else if (i_we) begin
            case (jets_pkg::t_cfg_idx'(i_idx))
                jets_pkg::CFG_PIXEL_STEP:   r_cfg.pixel_step   <= i_wdata[jets_pkg::STEP_W-1:0];
                jets_pkg::CFG_CENTER_REAL:  r_cfg.center_real  <= i_wdata;
                jets_pkg::CFG_CENTER_IMAG:  r_cfg.center_imag  <= i_wdata;
                jets_pkg::CFG_CONST_REAL:   r_cfg.const_real   <= i_wdata;
                jets_pkg::CFG_CONST_IMAG:   r_cfg.const_imag   <= i_wdata;
                jets_pkg::CFG_ITER_LIMIT:   r_cfg.iter_limit   <= i_wdata[jets_pkg::CNT_W-1:0];
                jets_pkg::CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_wdata[jets_pkg::SIZE_W-1:0];
                jets_pkg::CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_wdata[jets_pkg::SIZE_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/jets_ctrl.sv =====
// jets_ctrl: sequencer for start-point setup and the escape-time iteration loop
// depends on jets_pkg; drives jets_dp through t_cmd, reads t_stat
module jets_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  jets_pkg::t_stat i_stat,
    output jets_pkg::t_cmd  o_cmd
);

    jets_pkg::t_state r_state;
    jets_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jets_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            jets_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = jets_pkg::ST_START_MUL;
                end
            end
            jets_pkg::ST_START_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = jets_pkg::ST_START;
            end
            jets_pkg::ST_START: begin
                o_cmd.set_start = 1'b1;
                n_state         = jets_pkg::ST_ITER_MUL;
            end
            jets_pkg::ST_ITER_MUL: begin
                if (i_stat.limit_hit) begin
                    n_state = jets_pkg::ST_DONE;
                end else begin
                    o_cmd.mul_iter = 1'b1;
                    n_state        = jets_pkg::ST_ITER_TEST;
                end
            end
            jets_pkg::ST_ITER_TEST: begin
                if (i_stat.below) begin
                    o_cmd.step = 1'b1;
                    n_state    = jets_pkg::ST_ITER_MUL;
                end else begin
                    n_state = jets_pkg::ST_DONE;
                end
            end
            jets_pkg::ST_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state    = jets_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jets_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/jets_dp.sv =====
// jets_dp: shared multiply unit, z update with saturation, escape test, output register
// depends on jets_pkg; commanded by jets_ctrl
module jets_dp #(
    parameter int FRAC_BITS = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jets_pkg::t_cfg                i_cfg,
    input  jets_pkg::t_cmd                i_cmd,
    input  logic [jets_pkg::COORD_W-1:0]  i_px,
    input  logic [jets_pkg::COORD_W-1:0]  i_py,
    output jets_pkg::t_stat               o_stat,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [jets_pkg::CNT_W-1:0]    o_count,
    output logic [jets_pkg::COORD_W-1:0]  o_x,
    output logic [jets_pkg::COORD_W-1:0]  o_y
);

    localparam int Z_W    = jets_pkg::Z_W;
    localparam int PROD_W = jets_pkg::PROD_W;
    localparam int WIDE_W = jets_pkg::WIDE_W;
    localparam int PAD_C  = Z_W - jets_pkg::COORD_W - 1;
    localparam int PAD_S  = Z_W - jets_pkg::SIZE_W;
    // |z|^2 threshold of 4; past 64 bits every magnitude counts as below
    localparam logic [WIDE_W-1:0] ESC_LIMIT = (2 * FRAC_BITS + 2 >= PROD_W) ?
        {1'b1, {PROD_W{1'b0}}} : (WIDE_W'(1) << (2 * FRAC_BITS + 2));

    logic [jets_pkg::COORD_W-1:0] r_px;
    logic [jets_pkg::COORD_W-1:0] r_py;
    logic signed [Z_W-1:0]        r_re;
    logic signed [Z_W-1:0]        r_im;
    logic signed [Z_W-1:0]        n_re;
    logic signed [Z_W-1:0]        n_im;
    logic [jets_pkg::CNT_W-1:0]   r_count;
    logic [jets_pkg::CNT_W-1:0]   n_count;
    logic signed [PROD_W-1:0]     r_p0;
    logic signed [PROD_W-1:0]     r_p1;
    logic signed [PROD_W-1:0]     r_p2;
    logic signed [Z_W-1:0]        w_a0, w_b0, w_a1, w_b1, w_a2, w_b2;
    logic signed [Z_W-1:0]        w_dx, w_dy, w_step;
    logic [WIDE_W-1:0]            w_mag;
    logic signed [PROD_W-1:0]     w_diff;
    logic r_out_valid;
    logic [jets_pkg::CNT_W-1:0]   r_out_count;
    logic [jets_pkg::COORD_W-1:0] r_out_x;
    logic [jets_pkg::COORD_W-1:0] r_out_y;

    // twice coordinate minus frame size, signed pixel offset from center
    assign w_dx   = $signed({{PAD_C{1'b0}}, r_px, 1'b0}) -
                    $signed({{PAD_S{1'b0}}, i_cfg.frame_width});
    assign w_dy   = $signed({{PAD_C{1'b0}}, r_py, 1'b0}) -
                    $signed({{PAD_S{1'b0}}, i_cfg.frame_height});
    assign w_step = $signed({1'b0, i_cfg.pixel_step});

    // operand select for the three shared 32x32 multipliers
    always_comb begin
        if (i_cmd.mul_start) begin
            w_a0 = w_dx;  w_b0 = w_step;
            w_a1 = w_dy;  w_b1 = w_step;
            w_a2 = '0;    w_b2 = '0;
        end else begin
            w_a0 = r_re;  w_b0 = r_re;
            w_a1 = r_im;  w_b1 = r_im;
            w_a2 = r_re;  w_b2 = r_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start || i_cmd.mul_iter) begin
            r_p0 <= PROD_W'(w_a0) * PROD_W'(w_b0);
            r_p1 <= PROD_W'(w_a1) * PROD_W'(w_b1);
            r_p2 <= PROD_W'(w_a2) * PROD_W'(w_b2);
        end
    end

    assign w_mag  = {1'b0, r_p0} + {1'b0, r_p1};
    assign w_diff = r_p0 - r_p1;

    always_comb begin
        n_re    = r_re;
        n_im    = r_im;
        n_count = r_count;
        if (i_cmd.load) begin
            n_count = '0;
        end else if (i_cmd.set_start) begin
            // center plus half the scaled offset, floor rounding
            n_re = jets_pkg::sat_z(WIDE_W'($signed(i_cfg.center_real)) +
                                   WIDE_W'(r_p0 >>> 1));
            n_im = jets_pkg::sat_z(WIDE_W'($signed(i_cfg.center_imag)) +
                                   WIDE_W'(r_p1 >>> 1));
        end else if (i_cmd.step) begin
            n_re    = jets_pkg::sat_z(WIDE_W'(w_diff >>> FRAC_BITS) +
                                      WIDE_W'($signed(i_cfg.const_real)));
            n_im    = jets_pkg::sat_z(WIDE_W'(r_p2 >>> (FRAC_BITS - 1)) +
                                      WIDE_W'($signed(i_cfg.const_imag)));
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_re    <= n_re;
        r_im    <= n_im;
        r_count <= n_count;
        if (i_cmd.load) begin
            r_px <= i_px;
            r_py <= i_py;
        end
    end

    // output register, frees the sequencer while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_count <= r_count;
            r_out_x     <= r_px;
            r_out_y     <= r_py;
        end
    end

    assign o_stat.limit_hit = (r_count == i_cfg.iter_limit);
    assign o_stat.below     = (w_mag < ESC_LIMIT);
    assign o_stat.out_full  = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_count    = r_out_count;
    assign o_x        = r_out_x;
    assign o_y        = r_out_y;

endmodule
